[sv/dsum_pkg.sv]
// shared types, constants and microcode table for the divisor-sum block
package dsum_pkg;

  localparam int VALUE_BITS_DEF = 40;
  localparam int SUM_BITS = 43;
  localparam logic [63:0] SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;

  localparam int STEP_BITS = 4;

  // microprogram step addresses
  localparam logic [STEP_BITS-1:0] S_LOAD  = 4'd0;
  localparam logic [STEP_BITS-1:0] S_TEST  = 4'd1;
  localparam logic [STEP_BITS-1:0] S_DIV   = 4'd2;
  localparam logic [STEP_BITS-1:0] S_CHK   = 4'd3;
  localparam logic [STEP_BITS-1:0] S_PINIT = 4'd4;
  localparam logic [STEP_BITS-1:0] S_PMUL  = 4'd5;
  localparam logic [STEP_BITS-1:0] S_PDIV  = 4'd6;
  localparam logic [STEP_BITS-1:0] S_PCHK  = 4'd7;
  localparam logic [STEP_BITS-1:0] S_AMUL  = 4'd8;
  localparam logic [STEP_BITS-1:0] S_NEXTD = 4'd9;
  localparam logic [STEP_BITS-1:0] S_FIN   = 4'd10;
  localparam logic [STEP_BITS-1:0] S_NMUL  = 4'd11;
  localparam logic [STEP_BITS-1:0] S_OUT   = 4'd12;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_PART_INIT,
    OP_MUL_PART,
    OP_MUL_ACC_PART,
    OP_NEXT_D,
    OP_MUL_ACC_N,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_SQ_GT_N,
    C_REM_NZ,
    C_REM_Z,
    C_N_LE1
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [STEP_BITS-1:0] target;
  } ucw_t;

  typedef struct packed {
    op_t  op;
    logic start;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic mul_done;
    logic div_done;
    logic sq_gt_n;
    logic rem_nz;
    logic n_le1;
  } stat_t;

  function automatic ucw_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucw_t w;
    w = '{op: OP_NONE, cond: C_NEXT, target: S_LOAD};
    case (step)
      S_LOAD:  w = '{op: OP_LOAD,         cond: C_NEXT,    target: S_LOAD};
      S_TEST:  w = '{op: OP_NONE,         cond: C_SQ_GT_N, target: S_FIN};
      S_DIV:   w = '{op: OP_DIV,          cond: C_NEXT,    target: S_LOAD};
      S_CHK:   w = '{op: OP_NONE,         cond: C_REM_NZ,  target: S_NEXTD};
      S_PINIT: w = '{op: OP_PART_INIT,    cond: C_NEXT,    target: S_LOAD};
      S_PMUL:  w = '{op: OP_MUL_PART,     cond: C_NEXT,    target: S_LOAD};
      S_PDIV:  w = '{op: OP_DIV,          cond: C_NEXT,    target: S_LOAD};
      S_PCHK:  w = '{op: OP_NONE,         cond: C_REM_Z,   target: S_PMUL};
      S_AMUL:  w = '{op: OP_MUL_ACC_PART, cond: C_NEXT,    target: S_LOAD};
      S_NEXTD: w = '{op: OP_NEXT_D,       cond: C_ALWAYS,  target: S_TEST};
      S_FIN:   w = '{op: OP_NONE,         cond: C_N_LE1,   target: S_OUT};
      S_NMUL:  w = '{op: OP_MUL_ACC_N,    cond: C_NEXT,    target: S_LOAD};
      S_OUT:   w = '{op: OP_OUT,          cond: C_ALWAYS,  target: S_LOAD};
      default: w = '{op: OP_NONE,         cond: C_ALWAYS,  target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

[sv/dsum_mul.sv]
// shift-add multiplier, one multiplier bit per cycle
module dsum_mul #(
  parameter int W = 43
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  output logic         done,
  output logic [W-1:0] prod
);

  logic         busy_r;
  logic         done_r;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  logic [W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      p_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= {a_r[W-2:0], 1'b0};
      b_r <= {1'b0, b_r[W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

[sv/dsum_div.sv]
// restoring divider, one quotient bit per cycle
module dsum_div #(
  parameter int NW = 40,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic          rem_zero
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r;
  logic [DW-1:0] dsr_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, dvd_r[NW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DW'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[DW-1:0];
      end
      dvd_r <= {dvd_r[NW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quot     = dvd_r;
  assign rem_zero = (rem_r == '0);

endmodule

[sv/dsum_seq.sv]
// microcode sequencer: step counter, control table lookup, conditional jumps
module dsum_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  dsum_pkg::stat_t stat,
  output dsum_pkg::ctl_t  ctl
);

  logic [dsum_pkg::STEP_BITS-1:0] pc_r;
  logic [dsum_pkg::STEP_BITS-1:0] pc_nxt;
  logic                           busy_r;
  logic                           busy_nxt;
  dsum_pkg::ucw_t                 cw;
  logic                           unit_op;
  logic                           unit_done;
  logic                           ready;
  logic                           take;

  assign cw = dsum_pkg::ucode_rom(pc_r);

  always_comb begin
    unit_op   = 1'b0;
    unit_done = 1'b0;
    ready     = 1'b1;
    case (cw.op)
      dsum_pkg::OP_LOAD: ready = stat.in_valid;
      dsum_pkg::OP_OUT:  ready = stat.out_free;
      dsum_pkg::OP_DIV: begin
        unit_op   = 1'b1;
        unit_done = stat.div_done;
      end
      dsum_pkg::OP_MUL_PART, dsum_pkg::OP_MUL_ACC_PART, dsum_pkg::OP_MUL_ACC_N: begin
        unit_op   = 1'b1;
        unit_done = stat.mul_done;
      end
      default: ready = 1'b1;
    endcase
    if (unit_op) begin
      ready = busy_r && unit_done;
    end
  end

  always_comb begin
    case (cw.cond)
      dsum_pkg::C_ALWAYS:  take = 1'b1;
      dsum_pkg::C_SQ_GT_N: take = stat.sq_gt_n;
      dsum_pkg::C_REM_NZ:  take = stat.rem_nz;
      dsum_pkg::C_REM_Z:   take = !stat.rem_nz;
      dsum_pkg::C_N_LE1:   take = stat.n_le1;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (unit_op && !busy_r) begin
      busy_nxt = 1'b1;
    end
    if (ready) begin
      busy_nxt = 1'b0;
      pc_nxt   = take ? cw.target : pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= dsum_pkg::S_LOAD;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign ctl.op     = cw.op;
  assign ctl.start  = unit_op && !busy_r;
  assign ctl.commit = ready;

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= dsum_pkg::S_OUT) else $error("step counter out of program");

  a_busy_unit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cw.op == dsum_pkg::OP_DIV || cw.op == dsum_pkg::OP_MUL_PART ||
                cw.op == dsum_pkg::OP_MUL_ACC_PART || cw.op == dsum_pkg::OP_MUL_ACC_N))
    else $error("waiting on a unit in a step without one");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("unit launched but sequencer not waiting");

endmodule

[sv/divisor_sum_by_trial_division_top.sv]
// divisor sum (sigma) by trial division: datapath, units and sequencer
// cost: one bit-serial division per trial divisor up to sqrt(n); each power of p removed
//   adds a multiply and a division, and each prime factor adds a multiply into the sum
// worst case is a prime near 2^VALUE_BITS, where every trial divisor up to its square root
//   runs the bit-serial divider in the trial loop; an input of 0 or 1 skips the trial loop
// one request in flight; the next can be taken as soon as the result is registered
// reset (synchronous, active low) returns the step counter to the load step, empty output
module divisor_sum_by_trial_division_top #(
  parameter int VALUE_BITS = dsum_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_value_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsum_pkg::SUM_BITS-1:0] out_divisor_sum
);

  // trial divisor fits in VALUE_BITS/2 + 2 bits
  localparam int DB  = VALUE_BITS / 2 + 2;
  // square of the trial divisor, may step just past the remaining value
  localparam int SQB = VALUE_BITS + 2;
  // running sum product: sigma(n) < 8n over the parameter range
  localparam int AB  = VALUE_BITS + 3;

  // datapath registers
  logic [VALUE_BITS-1:0] n_r;     // part of n not yet factored
  logic [DB-1:0]         d_r;     // trial divisor
  logic [SQB-1:0]        sq_r;    // d_r squared, kept by adding 2d+1
  logic [AB-1:0]         acc_r;   // product of the divisor sums so far
  logic [AB-1:0]         part_r;  // 1 + p + ... + p^e, built as part*p + 1

  logic                          out_valid_r;
  logic [dsum_pkg::SUM_BITS-1:0] out_sum_r;

  dsum_pkg::ctl_t  ctl;
  dsum_pkg::stat_t stat;

  // shared multiplier and divider
  logic                  mul_done;
  logic [AB-1:0]         mul_a;
  logic [AB-1:0]         mul_b;
  logic [AB-1:0]         mul_p;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_q;
  logic                  div_rz;

  logic out_take;
  logic sat;

  // operand select for the multiplier, one source pair per microcode op
  always_comb begin
    case (ctl.op)
      dsum_pkg::OP_MUL_PART: begin
        mul_a = part_r;
        mul_b = AB'(d_r);
      end
      dsum_pkg::OP_MUL_ACC_PART: begin
        mul_a = acc_r;
        mul_b = part_r;
      end
      dsum_pkg::OP_MUL_ACC_N: begin
        mul_a = acc_r;
        mul_b = AB'(n_r) + AB'(1);
      end
      default: begin
        mul_a = acc_r;
        mul_b = part_r;
      end
    endcase
  end

  dsum_mul #(.W(AB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start && (ctl.op != dsum_pkg::OP_DIV)),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  dsum_div #(.NW(VALUE_BITS), .DW(DB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start && (ctl.op == dsum_pkg::OP_DIV)),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_q),
    .rem_zero (div_rz)
  );

  // status flags the microcode branches and waits on
  assign out_take      = out_valid_r && !out_stall;
  assign stat.in_valid = in_valid;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.sq_gt_n  = sq_r > SQB'(n_r);
  assign stat.rem_nz   = !div_rz;
  assign stat.n_le1    = n_r <= VALUE_BITS'(1);

  dsum_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // clamp to the result width (only reachable for wide VALUE_BITS)
  assign sat = 64'(acc_r) > dsum_pkg::SUM_MAX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      d_r    <= DB'(2);
      sq_r   <= SQB'(4);
      acc_r  <= AB'(1);
      part_r <= AB'(1);
    end else begin
      // quotient moves into n when the next power of p is started
      if (ctl.start && (ctl.op == dsum_pkg::OP_MUL_PART)) begin
        n_r <= div_q;
      end
      if (ctl.commit) begin
        case (ctl.op)
          dsum_pkg::OP_LOAD: begin
            n_r   <= in_value_in;
            d_r   <= DB'(2);
            sq_r  <= SQB'(4);
            acc_r <= AB'(1);
          end
          dsum_pkg::OP_PART_INIT:    part_r <= AB'(1);
          dsum_pkg::OP_MUL_PART:     part_r <= mul_p + AB'(1);
          dsum_pkg::OP_MUL_ACC_PART: acc_r  <= mul_p;
          dsum_pkg::OP_MUL_ACC_N:    acc_r  <= mul_p;
          dsum_pkg::OP_NEXT_D: begin
            d_r  <= d_r + DB'(1);
            sq_r <= sq_r + SQB'({d_r, 1'b1});
          end
          default: ;
        endcase
      end
    end
  end

  // output register: a finished result waits here while the next request loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit && (ctl.op == dsum_pkg::OP_OUT)) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && (ctl.op == dsum_pkg::OP_OUT)) begin
      out_sum_r <= sat ? dsum_pkg::SUM_MAX[dsum_pkg::SUM_BITS-1:0]
                       : dsum_pkg::SUM_BITS'(acc_r);
    end
  end

  assign in_stall        = (ctl.op != dsum_pkg::OP_LOAD);
  assign out_valid       = out_valid_r;
  assign out_divisor_sum = out_sum_r;

  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    sq_r == SQB'(SQB'(d_r) * SQB'(d_r))) else $error("square register lost track of divisor");

  a_acc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r != '0) else $error("divisor sum product became zero");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !(ctl.commit && (ctl.op == dsum_pkg::OP_OUT))) |=> !out_valid_r)
    else $error("result repeated after being taken");

endmodule
